// File: design/color_histogram_spatial_moments_top_macros.svh
// Assertion macros for the color histogram block.
// Used by files that assert; expects i_clk and i_rst_n in scope.
`ifndef COLOR_HISTOGRAM_SPATIAL_MOMENTS_TOP_MACROS_SVH
`define COLOR_HISTOGRAM_SPATIAL_MOMENTS_TOP_MACROS_SVH

// same-cycle implication
`define CHSM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHSM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/chsm_pkg.sv
// Shared types, widths and codes of the color histogram block.
// No dependencies.
`default_nettype none

package chsm_pkg;

    localparam int BPC_DEF        = 8;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam int CH_W   = 8;
    localparam int POS_W  = 11;
    localparam int SEL_W  = 9;
    localparam int FUNC_W = 2;
    localparam int CNT_W  = 23;
    localparam int SX_W   = 32;
    localparam int SX2_W  = 43;
    localparam int CFG_AW = 3;

    // function codes; any other code acts as a read
    localparam logic [FUNC_W-1:0] FUNC_ACC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_L_MIN = 3'd0;
    localparam logic [CFG_AW-1:0] REG_L_MAX = 3'd1;
    localparam logic [CFG_AW-1:0] REG_A_MIN = 3'd2;
    localparam logic [CFG_AW-1:0] REG_A_MAX = 3'd3;
    localparam logic [CFG_AW-1:0] REG_B_MIN = 3'd4;
    localparam logic [CFG_AW-1:0] REG_B_MAX = 3'd5;

    typedef struct packed {
        logic [CH_W-1:0] lo;
        logic [CH_W-1:0] hi;
    } t_chan_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_str_stat;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SX_W-1:0]  sx;
        logic [SX_W-1:0]  sy;
        logic [SX2_W-1:0] sx2;
        logic [SX2_W-1:0] sy2;
    } t_entry;

    typedef enum logic [2:0] {
        SP_IDLE,
        SP_MUL,
        SP_PREP,
        SP_DIV,
        SP_FIN
    } t_str_phase;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_STRETCH,
        S_ADDR,
        S_UPD,
        S_WRITE
    } t_state;

endpackage

`default_nettype wire

// File: design/color_histogram_spatial_moments_top.sv
// Top level of the Lab color histogram with spatial moments.
// Uses chsm_pkg, chsm_stretch, chsm_store and the assertion macro header.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+-------------------------------------
//   input    | i_in_valid   | o_in_stall   | i_func, i_l/a/b_value, i_x/y_pos,
//            |              |              | i_bin_select
//   output   | o_out_valid  | i_out_stall  | o_bin_index, o_bin_count, o_sum_*
//   config   | i_cfg_we     | -            | i_cfg_addr, i_cfg_data
//
// A pixel word passes through the stretch unit (eight-step divider), then the
// bin read, update and write steps (S_ADDR, S_UPD, S_WRITE); the next word is
// taken once the write step completes and the state returns to idle.
// A read or clear word skips the stretch and goes straight to the bin read.
// Reset starts a clearing pass over all BPC^3 bins (512 by default), input stalled.
// One word in flight; a stalled result holds the write step, memory written at most once.
`default_nettype none

module color_histogram_spatial_moments_top #(
    parameter int BPC        = chsm_pkg::BPC_DEF,
    parameter int MAX_WIDTH  = chsm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = chsm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [chsm_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [chsm_pkg::CH_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [chsm_pkg::FUNC_W-1:0]   i_func,
    input  logic [chsm_pkg::CH_W-1:0]     i_l_value,
    input  logic [chsm_pkg::CH_W-1:0]     i_a_value,
    input  logic [chsm_pkg::CH_W-1:0]     i_b_value,
    input  logic [chsm_pkg::POS_W-1:0]    i_x_pos,
    input  logic [chsm_pkg::POS_W-1:0]    i_y_pos,
    input  logic [chsm_pkg::SEL_W-1:0]    i_bin_select,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [chsm_pkg::SEL_W-1:0]    o_bin_index,
    output logic [chsm_pkg::CNT_W-1:0]    o_bin_count,
    output logic [chsm_pkg::SX_W-1:0]     o_sum_x,
    output logic [chsm_pkg::SX_W-1:0]     o_sum_y,
    output logic [chsm_pkg::SX2_W-1:0]    o_sum_x2,
    output logic [chsm_pkg::SX2_W-1:0]    o_sum_y2
);
    import chsm_pkg::*;

`include "color_histogram_spatial_moments_top_macros.svh"

    localparam int NUM_BINS = BPC * BPC * BPC;
    localparam int AW       = $clog2(NUM_BINS);
    localparam int BW       = $clog2(BPC);
    localparam int SQ_W     = 2 * POS_W;
    localparam int XLIM     = MAX_WIDTH - 1;
    localparam int YLIM     = MAX_HEIGHT - 1;

    t_state r_state, n_state;

    t_chan_cfg [2:0]   r_cfg;
    logic [AW-1:0]     r_clr;
    logic [FUNC_W-1:0] r_func;
    logic              r_sel_ok;
    logic              r_wr_need;
    logic [POS_W-1:0]  r_x, r_y;
    logic [SQ_W-1:0]   r_x2, r_y2;
    logic [AW-1:0]     r_addr;
    logic [SEL_W-1:0]  r_idx;
    t_entry            r_new;
    t_entry            r_out;
    logic [SEL_W-1:0]  r_out_idx;
    logic              r_out_valid;

    logic              in_acc;
    logic              out_free;
    logic              str_start;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_entry            mem_wdata;
    logic              load_out;
    t_entry            rdata;
    t_entry            n_new;
    t_str_stat         st_stat;
    logic [2:0][BW-1:0] st_bin;

    logic [CNT_W:0]    cnt_sum;
    logic [SX_W:0]     sx_sum, sy_sum;
    logic [SX2_W:0]    sx2_sum, sy2_sum;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    chsm_stretch #(
        .BPC (BPC)
    ) u_stretch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (str_start),
        .i_val   ({i_b_value, i_a_value, i_l_value}),
        .i_cfg   (r_cfg),
        .o_stat  (st_stat),
        .o_bin   (st_bin)
    );

    chsm_store #(
        .DEPTH (NUM_BINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(NUM_BINS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) n_state = (i_func == FUNC_ACC) ? S_STRETCH : S_ADDR;
            end
            S_STRETCH: begin
                if (st_stat.done) n_state = S_ADDR;
            end
            S_ADDR:  n_state = S_UPD;
            S_UPD:   n_state = S_WRITE;
            S_WRITE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        str_start  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_addr;
        mem_wdata  = r_new;
        load_out   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                str_start  = i_in_valid && (i_func == FUNC_ACC);
            end
            S_WRITE: begin
                load_out = out_free;
                mem_we   = out_free && r_wr_need;
            end
            default: begin
            end
        endcase
    end

    // saturating read-modify-write of one bin
    always_comb begin
        cnt_sum = {1'b0, rdata.cnt} + (CNT_W + 1)'(1);
        sx_sum  = {1'b0, rdata.sx} + (SX_W + 1)'(r_x);
        sy_sum  = {1'b0, rdata.sy} + (SX_W + 1)'(r_y);
        sx2_sum = {1'b0, rdata.sx2} + (SX2_W + 1)'(r_x2);
        sy2_sum = {1'b0, rdata.sy2} + (SX2_W + 1)'(r_y2);
        n_new   = '0;
        case (r_func)
            FUNC_ACC: begin
                n_new.cnt = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
                n_new.sx  = sx_sum[SX_W] ? '1 : sx_sum[SX_W-1:0];
                n_new.sy  = sy_sum[SX_W] ? '1 : sy_sum[SX_W-1:0];
                n_new.sx2 = sx2_sum[SX2_W] ? '1 : sx2_sum[SX2_W-1:0];
                n_new.sy2 = sy2_sum[SX2_W] ? '1 : sy2_sum[SX2_W-1:0];
            end
            FUNC_CLEAR: n_new = '0;
            default: begin
                if (r_sel_ok) n_new = rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_cfg[0]    <= '{lo: '0, hi: '1};
            r_cfg[1]    <= '{lo: '0, hi: '1};
            r_cfg[2]    <= '{lo: '0, hi: '1};
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_L_MIN: r_cfg[0].lo <= i_cfg_data;
                    REG_L_MAX: r_cfg[0].hi <= i_cfg_data;
                    REG_A_MIN: r_cfg[1].lo <= i_cfg_data;
                    REG_A_MAX: r_cfg[1].hi <= i_cfg_data;
                    REG_B_MIN: r_cfg[2].lo <= i_cfg_data;
                    REG_B_MAX: r_cfg[2].hi <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func    <= i_func;
            r_sel_ok  <= int'(i_bin_select) < NUM_BINS;
            r_wr_need <= (i_func == FUNC_ACC) ||
                         ((i_func == FUNC_CLEAR) && (int'(i_bin_select) < NUM_BINS));
            r_x       <= (int'(i_x_pos) > XLIM) ? POS_W'(XLIM) : i_x_pos;
            r_y       <= (int'(i_y_pos) > YLIM) ? POS_W'(YLIM) : i_y_pos;
            r_addr    <= AW'(i_bin_select);
            r_idx     <= i_bin_select;
        end
        if (r_state == S_STRETCH && st_stat.done) begin
            r_addr <= AW'(int'(st_bin[0]) + int'(st_bin[1]) * BPC
                          + int'(st_bin[2]) * BPC * BPC);
            r_idx  <= SEL_W'(int'(st_bin[0]) + int'(st_bin[1]) * BPC
                          + int'(st_bin[2]) * BPC * BPC);
        end
        if (r_state == S_ADDR) begin
            r_x2 <= SQ_W'(r_x) * SQ_W'(r_x);
            r_y2 <= SQ_W'(r_y) * SQ_W'(r_y);
        end
        if (r_state == S_UPD) begin
            r_new <= n_new;
        end
        if (load_out) begin
            r_out     <= r_new;
            r_out_idx <= r_idx;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bin_index = r_out_idx;
    assign o_bin_count = r_out.cnt;
    assign o_sum_x     = r_out.sx;
    assign o_sum_y     = r_out.sy;
    assign o_sum_x2    = r_out.sx2;
    assign o_sum_y2    = r_out.sy2;

    `CHSM_ASSERT_IMP(a_out_from_write, $rose(o_out_valid),
        $past(r_state) == S_WRITE, "result word appeared outside the write step")
    `CHSM_ASSERT_NXT(a_acc_starts_stretch, in_acc && i_func == FUNC_ACC,
        st_stat.busy && r_state == S_STRETCH, "pixel word did not start the stretch unit")
    `CHSM_ASSERT_IMP(a_done_while_waiting, st_stat.done,
        r_state == S_STRETCH, "stretch finished while nothing waited for it")
    `CHSM_ASSERT_IMP(a_acc_count_nonzero, mem_we && r_state == S_WRITE && r_func == FUNC_ACC,
        mem_wdata.cnt != '0, "accumulated bin written with zero count")

endmodule

`default_nettype wire

// File: design/chsm_stretch.sv
// Contrast stretch and channel binning for the three Lab channels.
// Shared-step restoring divider per lane; depends on chsm_pkg.
`default_nettype none

module chsm_stretch #(
    parameter int BPC = chsm_pkg::BPC_DEF,
    localparam int BW = $clog2(BPC)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [2:0][chsm_pkg::CH_W-1:0]   i_val,
    input  chsm_pkg::t_chan_cfg [2:0]        i_cfg,
    output chsm_pkg::t_str_stat              o_stat,
    output logic [2:0][BW-1:0]               o_bin
);
    import chsm_pkg::*;

    localparam int N_W  = 2 * CH_W;
    localparam int CW   = $clog2(CH_W);
    localparam int PW   = CH_W + $clog2(BPC + 1);

    t_str_phase r_phase, n_phase;
    logic [CW-1:0] r_cnt;
    logic          r_done;

    logic [CH_W-1:0] r_rng [3];
    logic [CH_W-1:0] r_d   [3];
    logic [N_W-1:0]  r_n   [3];
    logic            r_use [3];
    logic [CH_W-1:0] r_rem [3];
    logic [CH_W-1:0] r_low [3];
    logic [CH_W-1:0] r_quo [3];
    logic [BW-1:0]   r_bin [3];

    logic [CH_W-1:0] rng_c [3];
    logic [CH_W-1:0] d_c   [3];
    logic [N_W-1:0]  dvd_c [3];
    logic [CH_W:0]   t_c   [3];
    logic            ge_c  [3];
    logic [CH_W:0]   s9_c  [3];
    logic [CH_W-1:0] s_c   [3];
    logic [PW-1:0]   prod_c [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rng_c[k] = (i_cfg[k].hi >= i_cfg[k].lo) ? i_cfg[k].hi - i_cfg[k].lo : '0;
            d_c[k]   = (i_val[k] > i_cfg[k].lo) ? i_val[k] - i_cfg[k].lo : '0;
            if (d_c[k] > rng_c[k]) begin
                d_c[k] = rng_c[k];
            end
            dvd_c[k] = r_n[k] - N_W'(1);
            t_c[k]   = {r_rem[k], r_low[k][CH_W-1]};
            ge_c[k]  = t_c[k] >= {1'b0, r_rng[k]};
            s9_c[k]  = r_use[k] ? {1'b0, r_d[k]} + {1'b0, r_quo[k]} : {1'b0, r_d[k]};
            s_c[k]   = s9_c[k][CH_W] ? '1 : s9_c[k][CH_W-1:0];
            prod_c[k] = PW'(s_c[k]) * PW'(BPC);
        end
    end

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            SP_IDLE: begin
                if (i_start) n_phase = SP_MUL;
            end
            SP_MUL:  n_phase = SP_PREP;
            SP_PREP: n_phase = SP_DIV;
            SP_DIV: begin
                if (r_cnt == CW'(CH_W - 1)) n_phase = SP_FIN;
            end
            SP_FIN:  n_phase = SP_IDLE;
            default: n_phase = SP_IDLE;
        endcase
    end

    always_comb begin
        o_stat.busy = (r_phase != SP_IDLE);
        o_stat.done = r_done;
        for (int k = 0; k < 3; k++) begin
            o_bin[k] = r_bin[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= SP_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == SP_FIN);
            r_cnt   <= (r_phase == SP_DIV) ? r_cnt + CW'(1) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            case (r_phase)
                SP_IDLE: begin
                    if (i_start) begin
                        r_rng[k] <= rng_c[k];
                        r_d[k]   <= d_c[k];
                    end
                end
                SP_MUL: begin
                    r_n[k] <= N_W'(r_d[k]) * N_W'(8'd255 - r_rng[k]);
                end
                SP_PREP: begin
                    // quotient fits in 8 bits since N - 1 < 256 * r
                    r_use[k] <= (r_n[k] != '0) && (r_rng[k] != '0);
                    r_rem[k] <= dvd_c[k][N_W-1:CH_W];
                    r_low[k] <= dvd_c[k][CH_W-1:0];
                    r_quo[k] <= '0;
                end
                SP_DIV: begin
                    r_low[k] <= {r_low[k][CH_W-2:0], 1'b0};
                    r_quo[k] <= {r_quo[k][CH_W-2:0], ge_c[k]};
                    r_rem[k] <= ge_c[k] ? CH_W'(t_c[k] - {1'b0, r_rng[k]}) : t_c[k][CH_W-1:0];
                end
                SP_FIN: begin
                    r_bin[k] <= prod_c[k][CH_W +: BW];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/chsm_store.sv
// Bin store: one synchronous memory holding count and moment sums per bin.
// Registered read, one write port; depends on chsm_pkg.
`default_nettype none

module chsm_store #(
    parameter int DEPTH = 512,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  chsm_pkg::t_entry i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output chsm_pkg::t_entry o_rdata
);
    import chsm_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
